// ===== hw/rtl/serial_command_line_parser_macros.svh =====
// assertion macros used by the serial command line parser checker
// needs a clock named clk and an active low reset named rst_n in scope
`ifndef SERIAL_COMMAND_LINE_PARSER_MACROS_SVH
`define SERIAL_COMMAND_LINE_PARSER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SCLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SCLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sclp_pkg.sv =====
// shared types, character codes and helpers of the serial command line parser
// no dependencies
`default_nettype none

package sclp_pkg;

    // width of each decimal field accumulator, 8 to 64
    localparam int AccWidth = 32;
    localparam int OutWidth = 32;

    typedef enum logic [2:0] {
        MODE_NONE    = 3'd0,
        MODE_MOVE    = 3'd1,
        MODE_HOME    = 3'd2,
        MODE_DELAY   = 3'd3,
        MODE_DISABLE = 3'd4,
        MODE_ENABLE  = 3'd5,
        MODE_COMMENT = 3'd6
    } mode_t;

    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] CHAR_V     = 8'h56;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    localparam logic [2:0] IDX_MAX = 3'd7;

    // accumulator shown on a 32 bit result field
    function automatic logic [OutWidth-1:0] to_out(input logic [AccWidth-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OutWidth-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/serial_command_line_parser.sv =====
// Serial command line parser. Takes one ASCII byte per transaction on the char
// channel and returns one result transaction for every ';' that is not skipped.
// A byte is registered at the input, decoded against the line state in the next
// cycle and the result lands in an output register that drives res_valid. One
// byte is taken every cycle; the input stalls only when a ';' must write the
// output register while it still holds a result that the receiver stalls.
// Depends on sclp_pkg.
`default_nettype none

module serial_command_line_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic [7:0]  char_in,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [2:0]       mode,
    output logic [31:0]      first_value,
    output logic [31:0]      second_value,
    output logic [31:0]      check_value,
    output logic             valid_res
);

    localparam int AccW = sclp_pkg::AccWidth;

    // input register
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       char_reg;

    // line state
    sclp_pkg::mode_t  mode_reg;
    sclp_pkg::mode_t  mode_next;
    logic [2:0]       idx_reg;
    logic [2:0]       idx_next;
    logic [AccW-1:0]  acc_reg [3];
    logic [AccW-1:0]  acc_next [3];
    logic             skip_reg;
    logic             skip_next;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    sclp_pkg::mode_t  out_mode_reg;
    logic [31:0]      out_first_reg;
    logic [31:0]      out_second_reg;
    logic [31:0]      out_check_reg;
    logic             out_ok_reg;

    logic             produce;
    logic             out_free;
    logic             fire;
    logic [1:0]       acc_sel;
    logic [AccW-1:0]  acc_cur;
    logic [AccW-1:0]  acc_dec;
    logic [31:0]      f1;
    logic [31:0]      f2;
    logic [31:0]      f3;
    logic             ok;

    assign acc_sel = 2'(idx_reg - 3'd1);
    assign acc_cur = acc_reg[acc_sel];
    assign acc_dec = (acc_cur << 3) + (acc_cur << 1) + AccW'(char_reg[3:0]);

    assign f1 = sclp_pkg::to_out(acc_reg[0]);
    assign f2 = sclp_pkg::to_out(acc_reg[1]);
    assign f3 = sclp_pkg::to_out(acc_reg[2]);
    assign ok = !((mode_reg == sclp_pkg::MODE_MOVE) && ((f1 + f2) != f3));

    always_comb
    begin
        mode_next = mode_reg;
        idx_next  = idx_reg;
        acc_next  = acc_reg;
        skip_next = 1'b0;
        produce   = 1'b0;
        if (!skip_reg)
        begin
            case (char_reg)
                sclp_pkg::CHAR_M: mode_next = sclp_pkg::MODE_MOVE;
                sclp_pkg::CHAR_H: mode_next = sclp_pkg::MODE_HOME;
                sclp_pkg::CHAR_D: mode_next = sclp_pkg::MODE_DELAY;
                sclp_pkg::CHAR_S: mode_next = sclp_pkg::MODE_DISABLE;
                sclp_pkg::CHAR_A,
                sclp_pkg::CHAR_B: mode_next = sclp_pkg::MODE_ENABLE;
                sclp_pkg::CHAR_V: mode_next = sclp_pkg::MODE_COMMENT;
                sclp_pkg::CHAR_C:
                begin
                    mode_next = sclp_pkg::MODE_COMMENT;
                    skip_next = 1'b1;
                    if (idx_reg != sclp_pkg::IDX_MAX)
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                sclp_pkg::CHAR_COMMA:
                begin
                    if (idx_reg != sclp_pkg::IDX_MAX)
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                sclp_pkg::CHAR_SEMI:
                begin
                    produce   = 1'b1;
                    mode_next = sclp_pkg::MODE_NONE;
                    idx_next  = 3'd0;
                    acc_next  = '{default: '0};
                end
                default:
                begin
                    // digits only land in fields one to three outside comments
                    if ((char_reg inside {[sclp_pkg::CHAR_0:sclp_pkg::CHAR_9]}) &&
                        (idx_reg inside {[3'd1:3'd3]}) &&
                        (mode_reg != sclp_pkg::MODE_COMMENT))
                    begin
                        acc_next[acc_sel] = acc_dec;
                    end
                end
            endcase
        end
    end

    assign out_free   = !out_valid_reg || !res_stall;
    assign fire       = in_valid_reg && (!produce || out_free);
    assign char_stall = in_valid_reg && !fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (char_valid && !char_stall)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= sclp_pkg::MODE_NONE;
            idx_reg       <= 3'd0;
            acc_reg       <= '{default: '0};
            skip_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                mode_reg <= mode_next;
                idx_reg  <= idx_next;
                acc_reg  <= acc_next;
                skip_reg <= skip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            char_reg <= char_in;
        end
        if (fire && produce)
        begin
            out_mode_reg   <= mode_reg;
            out_first_reg  <= f1;
            out_second_reg <= f2;
            out_check_reg  <= f3;
            out_ok_reg     <= ok;
        end
    end

    assign res_valid    = out_valid_reg;
    assign mode         = out_mode_reg;
    assign first_value  = out_first_reg;
    assign second_value = out_second_reg;
    assign check_value  = out_check_reg;
    assign valid_res    = out_ok_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sclp_checker.sv =====
// port level checks of the serial command line parser, bound to the parser module
// depends on sclp_pkg and serial_command_line_parser_macros.svh
`default_nettype none

`include "serial_command_line_parser_macros.svh"

module sclp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        char_valid,
    input wire logic        char_stall,
    input wire logic [7:0]  char_in,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic [2:0]  mode,
    input wire logic [31:0] first_value,
    input wire logic [31:0] second_value,
    input wire logic [31:0] check_value,
    input wire logic        valid_res
);

    // a stalled result stays valid and keeps its mode, first field and checksum flag
    `SCLP_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
        res_valid && $stable(mode) && $stable(first_value) && $stable(valid_res),
        "stalled result changed")

    // checksum flag follows the fields for move, stays set otherwise
    `SCLP_ASSERT_NOW(a_checksum, res_valid,
        valid_res == ((mode != sclp_pkg::MODE_MOVE) ||
                      ((first_value + second_value) == check_value)),
        "checksum flag wrong")

    // a fresh result comes from an earlier accepted ';'
    `SCLP_ASSERT_NOW(a_result_source, $rose(res_valid),
        $past(char_valid && !char_stall, 2) && ($past(char_in, 2) == sclp_pkg::CHAR_SEMI),
        "result without a terminating semicolon")

    // with the output register empty, the input never stalls
    `SCLP_ASSERT_NOW(a_no_stall_empty, !res_valid, !char_stall,
        "input stalled with empty output")

endmodule

bind serial_command_line_parser sclp_checker u_sclp_checker (.*);

`default_nettype wire

// ===== dv/sclp_line_checker.sv =====
// line checker for serial_command_line_parser: watches both channels, predicts each
// line result from the accepted characters and compares field by field
// depends on sclp_pkg
`default_nettype none

module sclp_line_checker
    import sclp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    input  wire logic        char_stall,
    input  wire logic [7:0]  char_in,
    input  wire logic        res_valid,
    input  wire logic        res_stall,
    input  wire logic [2:0]  mode,
    input  wire logic [31:0] first_value,
    input  wire logic [31:0] second_value,
    input  wire logic [31:0] check_value,
    input  wire logic        valid_res,
    output int               fail_count,
    output int               lines_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumFields = 3;
    localparam int ReportLimit = 10;

    typedef struct packed {
        mode_t                mode;
        logic [OutWidth-1:0]  first;
        logic [OutWidth-1:0]  second;
        logic [OutWidth-1:0]  check;
        logic                 sum_ok;
    } line_result_t;

    line_result_t line_results_q[$];

    // line state as the parser should hold it
    mode_t               line_mode;
    logic [2:0]          field_idx;
    logic [AccWidth-1:0] field_sum [NumFields];
    logic                swallow_next;

    function automatic void clear_line();
        line_mode    = MODE_NONE;
        field_idx    = '0;
        swallow_next = 1'b0;
        for (int k = 0; k < NumFields; k++) field_sum[k] = '0;
    endfunction

    function automatic void bump_field();
        if (field_idx != IDX_MAX) field_idx = field_idx + 3'd1;
    endfunction

    function automatic void parse_char(input logic [7:0] ch);
        line_result_t        res;
        logic [OutWidth-1:0] total;
        logic [2:0]          k;
        if (swallow_next)
        begin
            swallow_next = 1'b0;
            return;
        end
        case (ch)
            CHAR_M: line_mode = MODE_MOVE;
            CHAR_H: line_mode = MODE_HOME;
            CHAR_D: line_mode = MODE_DELAY;
            CHAR_S: line_mode = MODE_DISABLE;
            CHAR_A, CHAR_B: line_mode = MODE_ENABLE;
            CHAR_V: line_mode = MODE_COMMENT;
            CHAR_C:
            begin
                line_mode = MODE_COMMENT;
                bump_field();
                swallow_next = 1'b1;
            end
            CHAR_COMMA: bump_field();
            CHAR_SEMI:
            begin
                res.mode   = line_mode;
                res.first  = OutWidth'(field_sum[0]);
                res.second = OutWidth'(field_sum[1]);
                res.check  = OutWidth'(field_sum[2]);
                total      = res.first + res.second;
                res.sum_ok = !(line_mode == MODE_MOVE && total != res.check);
                line_results_q.push_back(res);
                clear_line();
            end
            default:
            begin
                if (ch >= CHAR_0 && ch <= CHAR_9 && field_idx >= 3'd1
                        && field_idx <= 3'(NumFields) && line_mode != MODE_COMMENT)
                begin
                    k = field_idx - 3'd1;
                    field_sum[k] = field_sum[k] * AccWidth'(10) + AccWidth'(ch - CHAR_0);
                end
            end
        endcase
    endfunction

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin : monitor
        line_result_t want;
        line_result_t got;
        if (!rst_n)
        begin
            clear_line();
            line_results_q.delete();
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                got.mode   = mode_t'(mode);
                got.first  = first_value;
                got.second = second_value;
                got.check  = check_value;
                got.sum_ok = valid_res;
                if (line_results_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= ReportLimit)
                        $display({"unexpected result transaction: mode %0d first %0d",
                                  " second %0d check %0d valid %0b"},
                                 got.mode, got.first, got.second, got.check, got.sum_ok);
                end
                else
                begin
                    want = line_results_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= ReportLimit)
                        begin
                            $display({"mismatch at %0t: expected mode %0d first %0d",
                                      " second %0d check %0d valid %0b"},
                                     $realtime, want.mode, want.first, want.second,
                                     want.check, want.sum_ok);
                            $display("    got mode %0d first %0d second %0d check %0d valid %0b",
                                     got.mode, got.first, got.second, got.check, got.sum_ok);
                        end
                    end
                end
            end
            if (char_valid && !char_stall) parse_char(char_in);
        end
        lines_pending = line_results_q.size();
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench top for serial_command_line_parser: clock, reset, character stimulus,
// receiver stalls, watchdog and verdict; line checking lives in sclp_line_checker
// depends on sclp_pkg, serial_command_line_parser and sclp_line_checker
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sclp_pkg::*;

    localparam int ItemTarget    = 1100;
    localparam int IdlePercent   = 25;
    localparam int HoldCycles    = 150;
    localparam int PressureLines = 20;
    localparam int DrainCycles   = 10;
    // quietest legal spell is the receiver hold-off, this is many times that
    localparam int WatchdogLimit = 2000;

    logic        clk;
    logic        rst_n;
    logic        char_valid;
    logic        char_stall;
    logic [7:0]  char_in;
    logic        res_valid;
    logic        res_stall;
    logic [2:0]  mode;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [31:0] check_value;
    logic        valid_res;

    int          fail_count;
    int          lines_pending;
    int          sent_count;
    int          hold_requests;
    logic        steady;
    logic [7:0]  line_q[$];

    serial_command_line_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_in      (char_in),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .mode         (mode),
        .first_value  (first_value),
        .second_value (second_value),
        .check_value  (check_value),
        .valid_res    (valid_res)
    );

    sclp_line_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_in       (char_in),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .mode          (mode),
        .first_value   (first_value),
        .second_value  (second_value),
        .check_value   (check_value),
        .valid_res     (valid_res),
        .fail_count    (fail_count),
        .lines_pending (lines_pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 7))
            0: return CHAR_M;
            1: return CHAR_H;
            2: return CHAR_D;
            3: return CHAR_S;
            4: return CHAR_A;
            5: return CHAR_B;
            6: return CHAR_V;
            default: return CHAR_C;
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 32'($urandom_range(0, 999));
        if (roll < 85) return 32'($urandom_range(0, 99999));
        return $urandom();
    endfunction

    task automatic add_char(input logic [7:0] ch);
        line_q.push_back(ch);
    endtask

    task automatic add_text(input string s);
        foreach (s[i]) line_q.push_back(s[i]);
    endtask

    task automatic add_long_digits();
        repeat ($urandom_range(10, 13)) add_char(CHAR_0 + 8'($urandom_range(0, 9)));
    endtask

    // well formed command with random content, sometimes after a stray byte
    task automatic make_command_line();
        logic [7:0]  letter;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] total;
        if ($urandom_range(0, 99) < 10) add_char(8'($urandom_range(0, 255)));
        letter = pick_letter();
        add_char(letter);
        if (letter == CHAR_C) add_char(8'($urandom_range(0, 255)));
        if (letter == CHAR_M)
        begin
            a = pick_value();
            b = pick_value();
            total = a + b;
            add_text($sformatf(",%0d,%0d,", a, b));
            add_text($sformatf("%0d",
                               ($urandom_range(0, 1) == 1) ? total : pick_value()));
        end
        else
        begin
            repeat ($urandom_range(0, 4))
            begin
                add_char(CHAR_COMMA);
                if ($urandom_range(0, 9) == 0)
                    add_long_digits();
                else
                    add_text($sformatf("%0d", pick_value()));
            end
        end
        add_char(CHAR_SEMI);
    endtask

    // junk and broken lines
    task automatic make_noise_line();
        int pick;
        if ($urandom_range(0, 9) == 0)
        begin
            // run the field index into its ceiling
            add_char(CHAR_M);
            repeat ($urandom_range(7, 10)) add_char(CHAR_COMMA);
            add_text("42");
        end
        else
        begin
            repeat ($urandom_range(1, 12))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    add_char(8'($urandom_range(0, 255)));
                else if (pick < 6)
                    add_char(CHAR_0 + 8'($urandom_range(0, 9)));
                else if (pick < 8)
                    add_char(CHAR_COMMA);
                else
                    add_char(pick_letter());
            end
        end
        if ($urandom_range(0, 9) < 7) add_char(CHAR_SEMI);
    endtask

    task automatic send_char(input logic [7:0] ch);
        while (!steady && $urandom_range(0, 99) < IdlePercent)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        char_in    <= ch;
        @(posedge clk);
        while (char_stall) @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_char(line_q[i]);
        line_q.delete();
    endtask

    // sender pauses until every line result is back
    task automatic drain();
        char_valid <= 1'b0;
        wait (lines_pending == 0);
        @(negedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        char_valid    = 1'b0;
        char_in       = '0;
        steady        = 1'b0;
        sent_count    = 0;
        hold_requests = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty line, byte extremes, stray digit, fields past the third
        add_char(CHAR_SEMI);
        add_char(8'h00);
        add_char(8'hFF);
        add_text("3M,7,,,9;");
        // semicolon swallowed after C
        add_text("C;D;");
        add_text("HSABV,5;");
        send_line();
        drain();

        // receiver holds off while short lines keep coming
        hold_requests++;
        repeat (PressureLines) add_text("H;");
        send_line();
        drain();

        while (sent_count < ItemTarget)
        begin
            steady = (sent_count >= 500 && sent_count < 700);
            if ($urandom_range(0, 99) < 70)
                make_command_line();
            else
                make_noise_line();
            send_line();
        end
        steady = 1'b0;
        drain();
        repeat (DrainCycles) @(posedge clk);

        if (lines_pending != 0)
            $display("%0d line results never arrived", lines_pending);
        if (fail_count == 0 && lines_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : receiver
        int served;
        served    = 0;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests > served)
            begin
                served++;
                repeat (HoldCycles)
                begin
                    res_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            res_stall <= !steady && ($urandom_range(0, 99) < IdlePercent);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WatchdogLimit)
        begin
            @(posedge clk);
            if ((char_valid && !char_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transaction for %0d cycles", WatchdogLimit);
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sclp_pkg.sv
hw/rtl/serial_command_line_parser.sv
hw/rtl/sclp_checker.sv
dv/sclp_line_checker.sv
dv/tb.sv
